// ----- rtl/acchb_pkg.sv -----
`default_nettype none
package acchb_pkg;

    localparam int VALUE_W   = 16;
    localparam int LABEL_W   = 8;
    localparam int CNT_W     = 11;
    localparam int PCT_W     = 7;
    localparam int CFG_IDX_W = 2;
    localparam int DIV_NUM_W = 18;
    localparam int DIV_DEN_W = 16;

    localparam logic [CNT_W-1:0]   CNT_MAX    = 11'h7FF;
    localparam logic [PCT_W-1:0]   PCT_SCALE  = 7'd100;
    localparam logic [VALUE_W-1:0] WIDTH_RST  = 16'h0100;
    localparam logic [VALUE_W-1:0] LOW_RST    = 16'h8000;
    localparam logic [VALUE_W-1:0] HIGH_RST   = 16'h7FFF;

    localparam logic [CFG_IDX_W-1:0] CFG_BIN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HIGH = 2'd2;

    localparam logic REQ_ADD    = 1'b0;
    localparam logic REQ_FINISH = 1'b1;

    typedef struct packed {
        logic                      req_type;
        logic [LABEL_W-1:0]        true_label;
        logic [LABEL_W-1:0]        predicted_label;
        logic signed [VALUE_W-1:0] sample_value;
    } t_req;

    typedef struct packed {
        logic signed [VALUE_W-1:0] bin_start;
        logic [CNT_W-1:0]          correct_count;
        logic [CNT_W-1:0]          incorrect_count;
        logic [PCT_W-1:0]          percent_correct;
        logic                      no_data;
        logic                      overflow;
        logic                      last;
    } t_result;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SPAN,
        S_SPAN_WAIT,
        S_CLEAR,
        S_RD_SMP,
        S_IDX_START,
        S_IDX_WAIT,
        S_BIN_RD,
        S_BIN_WR,
        S_EMIT_RD,
        S_PCT_START,
        S_PCT_WAIT
    } t_state;

    typedef struct packed {
        logic div_start;
        logic span_done;
        logic clear_wr;
        logic bin_wr;
        logic pct_start;
        logic emit_done;
    } t_ctl;

endpackage
`default_nettype wire

// ----- rtl/acchb_ram.sv -----
`default_nettype none
module acchb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ----- rtl/acchb_div.sv -----
`default_nettype none
module acchb_div
    import acchb_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [DIV_NUM_W-1:0] i_num,
    input  wire logic [DIV_DEN_W-1:0] i_den,
    output logic                      o_done,
    output logic      [DIV_NUM_W-1:0] o_quo
);

    localparam int CW = $clog2(DIV_NUM_W + 1);

    logic           r_busy;
    logic [CW-1:0]  r_cnt;
    logic [DIV_NUM_W-1:0] r_quo;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_DEN_W:0]   shifted;
    logic [DIV_DEN_W:0]   diff;

    // restoring, one quotient bit per cycle
    assign shifted = {r_rem, r_quo[DIV_NUM_W-1]};
    assign diff    = shifted - {1'b0, r_den};
    assign o_done  = r_busy && (r_cnt == '0);
    assign o_quo   = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(DIV_NUM_W);
        end else if (o_done) begin
            r_busy <= 1'b0;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy && (r_cnt != '0)) begin
            if (shifted >= {1'b0, r_den}) begin
                r_rem <= diff[DIV_DEN_W-1:0];
                r_quo <= {r_quo[DIV_NUM_W-2:0], 1'b1};
            end else begin
                r_rem <= shifted[DIV_DEN_W-1:0];
                r_quo <= {r_quo[DIV_NUM_W-2:0], 1'b0};
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/accuracy_histogram_binner.sv -----
// channel   | handshake                  | payload
// ----------+----------------------------+--------------------------
// request   | start in, busy out         | i_req    (t_req)
// result    | o_result_vld strobe        | o_result (t_result)
// config    | i_cfg_we                   | i_cfg_idx, i_cfg_data
//
// An add leaves busy low, so adds can come every cycle.
// A finish: divide for the bin count (none gives one no_data result), clear
// every bin, divide per stored sample for its bin and update it, then divide
// per bin for its percent and emit it, all on the shared one-bit-per-cycle divider.
// Reset is synchronous; no clearing pass is needed after it.
// Results are one-cycle strobes; the receiver cannot stall.
`default_nettype none
module accuracy_histogram_binner
    import acchb_pkg::*;
#(
    parameter int SAMPLE_DEPTH = 1024,
    parameter int MAX_BINS     = 64
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire t_req                 i_req,
    output logic                      o_result_vld,
    output t_result                   o_result,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [VALUE_W-1:0]   i_cfg_data
);

    localparam int SAW    = $clog2(SAMPLE_DEPTH);
    localparam int SCW    = $clog2(SAMPLE_DEPTH + 1);
    localparam int BAW    = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int BCW    = $clog2(MAX_BINS + 1);
    localparam int SMP_W  = VALUE_W + 1;
    localparam int BIN_W  = 2 * CNT_W;

    t_state r_state, n_state;
    t_ctl   ctl;

    logic [VALUE_W-1:0]        r_bin_width;
    logic signed [VALUE_W-1:0] r_range_low, r_range_high;
    logic [SCW-1:0]            r_count;
    logic signed [VALUE_W-1:0] r_min, r_max;
    logic                      r_full;
    logic                      r_cap;
    logic [BCW-1:0]            r_nbins;
    logic [BAW-1:0]            r_bin;
    logic [SCW-1:0]            r_idx;
    logic                      r_corr;
    logic [VALUE_W-1:0]        r_start;
    logic [CNT_W-1:0]          r_c, r_ic;
    logic [CNT_W:0]            r_tot;

    logic                      in_window;
    logic                      add_acc;
    logic [VALUE_W-1:0]        w_eff;
    logic [VALUE_W:0]          span_diff;
    logic [VALUE_W:0]          val_diff;
    logic [DIV_NUM_W-1:0]      div_num;
    logic [DIV_DEN_W-1:0]      div_den;
    logic                      div_done;
    logic [DIV_NUM_W-1:0]      div_quo;
    logic [BAW-1:0]            last_bin;
    logic [BAW-1:0]            idx_bin;
    logic [SMP_W-1:0]          smp_rdata;
    logic [BIN_W-1:0]          bin_rdata;
    logic                      bin_we;
    logic [BIN_W-1:0]          bin_wdata;
    logic [CNT_W-1:0]          rd_c, rd_ic;
    logic [DIV_NUM_W-1:0]      c_scaled;

    assign busy    = (r_state != S_IDLE);
    assign add_acc = start && !busy && (i_req.req_type == REQ_ADD);
    assign in_window = (i_req.sample_value >= r_range_low)
                    && (i_req.sample_value <= r_range_high);
    assign w_eff   = (r_bin_width == '0) ? VALUE_W'(1) : r_bin_width;
    assign last_bin = BAW'(r_nbins - 1'b1);

    // max >= min whenever samples exist, so both differences are non-negative
    assign span_diff = {r_max[VALUE_W-1], r_max} - {r_min[VALUE_W-1], r_min};
    assign val_diff  = {smp_rdata[VALUE_W-1], smp_rdata[VALUE_W-1:0]}
                     - {r_min[VALUE_W-1], r_min};

    assign {rd_c, rd_ic} = bin_rdata;
    assign c_scaled = DIV_NUM_W'(rd_c) * DIV_NUM_W'(PCT_SCALE);

    always_comb begin
        div_num = c_scaled;
        div_den = DIV_DEN_W'(rd_c) + DIV_DEN_W'(rd_ic);
        case (r_state)
            S_SPAN: begin
                div_num = (r_count == '0) ? DIV_NUM_W'(w_eff) - 1'b1
                        : DIV_NUM_W'(span_diff[VALUE_W-1:0]) + DIV_NUM_W'(w_eff) - 1'b1;
                div_den = w_eff;
            end
            S_IDX_START: begin
                div_num = DIV_NUM_W'(val_diff[VALUE_W-1:0]);
                div_den = w_eff;
            end
            default: begin
            end
        endcase
    end

    assign idx_bin = (div_quo >= DIV_NUM_W'(r_nbins)) ? last_bin : div_quo[BAW-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:      if (start && i_req.req_type == REQ_FINISH) n_state = S_SPAN;
            S_SPAN:      n_state = S_SPAN_WAIT;
            S_SPAN_WAIT: if (div_done) n_state = (div_quo == '0) ? S_IDLE : S_CLEAR;
            S_CLEAR:     if (r_bin == last_bin) n_state = S_RD_SMP;
            S_RD_SMP:    n_state = (r_idx == r_count) ? S_EMIT_RD : S_IDX_START;
            S_IDX_START: n_state = S_IDX_WAIT;
            S_IDX_WAIT:  if (div_done) n_state = S_BIN_RD;
            S_BIN_RD:    n_state = S_BIN_WR;
            S_BIN_WR:    n_state = S_RD_SMP;
            S_EMIT_RD:   n_state = S_PCT_START;
            S_PCT_START: n_state = S_PCT_WAIT;
            S_PCT_WAIT:  if (div_done) n_state = (r_bin == last_bin) ? S_IDLE : S_EMIT_RD;
            default:     n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        ctl = '0;
        unique case (r_state)
            S_SPAN:      ctl.div_start = 1'b1;
            S_SPAN_WAIT: ctl.span_done = div_done;
            S_CLEAR:     ctl.clear_wr  = 1'b1;
            S_IDX_START: ctl.div_start = 1'b1;
            S_BIN_WR:    ctl.bin_wr    = 1'b1;
            S_PCT_START: begin
                ctl.div_start = 1'b1;
                ctl.pct_start = 1'b1;
            end
            S_PCT_WAIT:  ctl.emit_done = div_done;
            default: begin
            end
        endcase
    end

    always_comb begin
        bin_we    = ctl.clear_wr || ctl.bin_wr;
        bin_wdata = '0;
        if (ctl.bin_wr) begin
            if (r_corr) begin
                bin_wdata = {(rd_c == CNT_MAX) ? rd_c : rd_c + 1'b1, rd_ic};
            end else begin
                bin_wdata = {rd_c, (rd_ic == CNT_MAX) ? rd_ic : rd_ic + 1'b1};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_bin_width  <= WIDTH_RST;
            r_range_low  <= LOW_RST;
            r_range_high <= HIGH_RST;
            r_count      <= '0;
            r_min        <= HIGH_RST;
            r_max        <= LOW_RST;
            r_full       <= 1'b0;
            o_result_vld <= 1'b0;
        end else begin
            r_state      <= n_state;
            o_result_vld <= ctl.emit_done || (ctl.span_done && div_quo == '0);
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_BIN_WIDTH:  r_bin_width  <= i_cfg_data;
                    CFG_RANGE_LOW:  r_range_low  <= i_cfg_data;
                    CFG_RANGE_HIGH: r_range_high <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (add_acc && in_window) begin
                if (r_count == SCW'(SAMPLE_DEPTH)) begin
                    r_full <= 1'b1;
                end else begin
                    r_count <= r_count + 1'b1;
                    if (i_req.sample_value < r_min) r_min <= i_req.sample_value;
                    if (i_req.sample_value > r_max) r_max <= i_req.sample_value;
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (ctl.span_done) begin
            r_bin <= '0;
            r_idx <= '0;
            if (div_quo > DIV_NUM_W'(MAX_BINS)) begin
                r_nbins <= BCW'(MAX_BINS);
                r_cap   <= 1'b1;
            end else begin
                r_nbins <= div_quo[BCW-1:0];
                r_cap   <= 1'b0;
            end
            if (div_quo == '0) begin
                o_result.bin_start       <= '0;
                o_result.correct_count   <= '0;
                o_result.incorrect_count <= '0;
                o_result.percent_correct <= '0;
                o_result.no_data         <= 1'b1;
                o_result.overflow        <= r_full;
                o_result.last            <= 1'b1;
            end
        end
        if (ctl.clear_wr) begin
            r_bin   <= (r_bin == last_bin) ? '0 : r_bin + 1'b1;
            r_start <= r_min;
        end
        if (r_state == S_IDX_START) r_corr <= smp_rdata[VALUE_W];
        if (r_state == S_IDX_WAIT && div_done) r_bin <= idx_bin;
        if (ctl.bin_wr) begin
            r_idx <= r_idx + 1'b1;
            r_bin <= '0;
        end
        if (ctl.pct_start) begin
            r_c   <= rd_c;
            r_ic  <= rd_ic;
            r_tot <= {1'b0, rd_c} + {1'b0, rd_ic};
        end
        if (ctl.emit_done) begin
            o_result.bin_start       <= r_start;
            o_result.correct_count   <= r_c;
            o_result.incorrect_count <= r_ic;
            o_result.percent_correct <= (r_tot == '0) ? '0 : div_quo[PCT_W-1:0];
            o_result.no_data         <= 1'b0;
            o_result.overflow        <= r_full || r_cap;
            o_result.last            <= (r_bin == last_bin);
            r_start <= r_start + w_eff;
            r_bin   <= r_bin + 1'b1;
        end
    end

    acchb_ram #(
        .WIDTH (SMP_W),
        .DEPTH (SAMPLE_DEPTH)
    ) u_smp_ram (
        .i_clk   (i_clk),
        .i_we    (add_acc && in_window && (r_count != SCW'(SAMPLE_DEPTH))),
        .i_waddr (r_count[SAW-1:0]),
        .i_wdata ({i_req.true_label == i_req.predicted_label, i_req.sample_value}),
        .i_raddr (r_idx[SAW-1:0]),
        .o_rdata (smp_rdata)
    );

    acchb_ram #(
        .WIDTH (BIN_W),
        .DEPTH (MAX_BINS)
    ) u_bin_ram (
        .i_clk   (i_clk),
        .i_we    (bin_we),
        .i_waddr (r_bin),
        .i_wdata (bin_wdata),
        .i_raddr (r_bin),
        .o_rdata (bin_rdata)
    );

    acchb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (ctl.div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_vld && o_result.last |=> !o_result_vld)
        else $error("result strobe after last");

    a_nodata_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_vld && o_result.no_data |-> o_result.last)
        else $error("no_data result not marked last");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= SCW'(SAMPLE_DEPTH))
        else $error("sample count past store depth");

    a_bin_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.bin_wr |-> (BCW'(r_bin) < r_nbins))
        else $error("bin update outside bin count");

endmodule
`default_nettype wire

// ----- bench/acchb_checker.sv -----
`default_nettype none
module acchb_checker
    import acchb_pkg::*;
#(
    parameter int SAMPLE_DEPTH = 1024,
    parameter int MAX_BINS     = 64
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    input  wire logic                 busy,
    input  wire t_req                 i_req,
    input  wire logic                 o_result_vld,
    input  wire t_result              o_result,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [VALUE_W-1:0]   i_cfg_data,
    output int                        o_errors,
    output int                        o_pending
);

    logic [VALUE_W-1:0]        width_reg;
    logic signed [VALUE_W-1:0] low_reg;
    logic signed [VALUE_W-1:0] high_reg;

    int   stored_value [SAMPLE_DEPTH];
    bit   stored_match [SAMPLE_DEPTH];
    int   stored_cnt;
    int   val_min;
    int   val_max;
    bit   store_full;

    t_result expected_bins[$];

    task automatic add_sample(input t_req r);
        int v;
        v = int'(r.sample_value);
        if (v > int'(high_reg) || v < int'(low_reg))
            return;
        if (stored_cnt >= SAMPLE_DEPTH) begin
            store_full = 1'b1;
            return;
        end
        stored_value[stored_cnt] = v;
        stored_match[stored_cnt] = (r.true_label == r.predicted_label);
        stored_cnt++;
        if (v < val_min) val_min = v;
        if (v > val_max) val_max = v;
    endtask

    task automatic build_histogram();
        longint  w;
        longint  span;
        longint  nb;
        longint  idx;
        int      good [MAX_BINS];
        int      bad [MAX_BINS];
        int      tot;
        bit      ov;
        t_result res;
        w  = (width_reg == '0) ? 1 : longint'(width_reg);
        ov = store_full;
        span = (stored_cnt == 0) ? 0 : longint'(val_max - val_min);
        nb = (span + w - 1) / w;
        res = '0;
        if (stored_cnt == 0 || nb == 0) begin
            res.no_data  = 1'b1;
            res.overflow = ov;
            res.last     = 1'b1;
            expected_bins.insert(expected_bins.size(), res);
            return;
        end
        if (nb > MAX_BINS) begin
            nb = MAX_BINS;
            ov = 1'b1;
        end
        for (int i = 0; i < MAX_BINS; i++) begin
            good[i] = 0;
            bad[i]  = 0;
        end
        for (int i = 0; i < stored_cnt; i++) begin
            idx = longint'(stored_value[i] - val_min) / w;
            if (idx >= nb) idx = nb - 1;
            if (stored_match[i]) begin
                if (good[idx] < int'(CNT_MAX)) good[idx]++;
            end else begin
                if (bad[idx] < int'(CNT_MAX)) bad[idx]++;
            end
        end
        for (int i = 0; i < nb; i++) begin
            tot = good[i] + bad[i];
            res = '0;
            res.bin_start       = VALUE_W'(longint'(val_min) + longint'(i) * w);
            res.correct_count   = CNT_W'(good[i]);
            res.incorrect_count = CNT_W'(bad[i]);
            res.percent_correct = (tot != 0) ? PCT_W'((100 * good[i]) / tot) : '0;
            res.overflow        = ov;
            res.last            = (i + 1 == nb);
            expected_bins.insert(expected_bins.size(), res);
        end
    endtask

    task automatic check_result(input t_result got);
        t_result want;
        if (expected_bins.size() == 0) begin
            $display("%0t: unexpected result transaction %h", $time, got);
            o_errors++;
            return;
        end
        want = expected_bins.pop_front();
        if (got.bin_start !== want.bin_start) begin
            $display("%0t: bin_start expected %0d actual %0d", $time,
                     want.bin_start, got.bin_start);
            o_errors++;
        end
        if (got.correct_count !== want.correct_count) begin
            $display("%0t: correct_count expected %0d actual %0d", $time,
                     want.correct_count, got.correct_count);
            o_errors++;
        end
        if (got.incorrect_count !== want.incorrect_count) begin
            $display("%0t: incorrect_count expected %0d actual %0d", $time,
                     want.incorrect_count, got.incorrect_count);
            o_errors++;
        end
        if (got.percent_correct !== want.percent_correct) begin
            $display("%0t: percent_correct expected %0d actual %0d", $time,
                     want.percent_correct, got.percent_correct);
            o_errors++;
        end
        if (got.no_data !== want.no_data) begin
            $display("%0t: no_data expected %b actual %b", $time,
                     want.no_data, got.no_data);
            o_errors++;
        end
        if (got.overflow !== want.overflow) begin
            $display("%0t: overflow expected %b actual %b", $time,
                     want.overflow, got.overflow);
            o_errors++;
        end
        if (got.last !== want.last) begin
            $display("%0t: last expected %b actual %b", $time, want.last, got.last);
            o_errors++;
        end
    endtask

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_reg  = WIDTH_RST;
            low_reg    = LOW_RST;
            high_reg   = HIGH_RST;
            stored_cnt = 0;
            val_min    = 32767;
            val_max    = -32768;
            store_full = 1'b0;
            expected_bins.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BIN_WIDTH:  width_reg = i_cfg_data;
                    CFG_RANGE_LOW:  low_reg = i_cfg_data;
                    CFG_RANGE_HIGH: high_reg = i_cfg_data;
                    default: ;
                endcase
            end
            if (start && !busy) begin
                if (i_req.req_type == REQ_FINISH)
                    build_histogram();
                else
                    add_sample(i_req);
            end
            if (o_result_vld)
                check_result(o_result);
        end
        o_pending = expected_bins.size();
    end

endmodule
`default_nettype wire

// ----- bench/tb_accuracy_histogram_binner.sv -----
`default_nettype none
module tb_accuracy_histogram_binner;
    import acchb_pkg::*;

    localparam int STALL_LIMIT = 200000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    t_req                 i_req;
    logic                 o_result_vld;
    t_result              o_result;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [VALUE_W-1:0]   i_cfg_data;
    int                   errors;
    int                   pending;
    int                   quiet_cycles;
    int                   gap_odds;
    int                   win_lo;
    int                   win_hi;

    accuracy_histogram_binner i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_req        (i_req),
        .o_result_vld (o_result_vld),
        .o_result     (o_result),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    acchb_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_req        (i_req),
        .o_result_vld (o_result_vld),
        .o_result     (o_result),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_errors     (errors),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // watchdog: cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_result_vld)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // busy only moves at the rising edge, so look at it on the falling one
    task automatic send(input t_req r);
        i_req <= r;
        start <= 1'b1;
        do @(negedge i_clk); while (busy);
        @(posedge i_clk);
    endtask

    task automatic add_sample(input int v, input logic [LABEL_W-1:0] t,
                              input logic [LABEL_W-1:0] p);
        t_req r;
        r.req_type        = REQ_ADD;
        r.true_label      = t;
        r.predicted_label = p;
        r.sample_value    = VALUE_W'(v);
        send(r);
    endtask

    task automatic finish_run();
        t_req r;
        r              = t_req'($urandom);
        r.req_type     = REQ_FINISH;
        send(r);
    endtask

    task automatic maybe_gap();
        if (gap_odds != 0 && $urandom_range(gap_odds - 1, 0) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(18, 1)) @(posedge i_clk);
        end
    endtask

    // drain all bins, then let the block settle before touching registers
    task automatic settle();
        start <= 1'b0;
        do @(negedge i_clk); while (pending != 0 || busy);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= VALUE_W'(data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_add();
        logic [LABEL_W-1:0] t;
        int                 v;
        t = LABEL_W'($urandom);
        if ($urandom_range(4, 0) == 0 || win_lo > win_hi)
            v = int'($signed(VALUE_W'($urandom)));
        else
            v = win_lo + int'($urandom_range(win_hi - win_lo, 0));
        add_sample(v, t, $urandom_range(1, 0) ? t : LABEL_W'($urandom));
    endtask

    initial begin
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_req      = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_BIN_WIDTH;
        i_cfg_data = '0;
        gap_odds   = 4;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty store, then one point twice: no bins either way; a sample at 612 then gives two bins
        finish_run();
        add_sample(100, 8'd7, 8'd7);
        finish_run();
        add_sample(100, 8'd7, 8'd9);
        finish_run();
        add_sample(612, 8'hFF, 8'hFF);
        finish_run();
        settle();
        cfg_write(CFG_RANGE_LOW, 0);
        cfg_write(CFG_RANGE_HIGH, 1000);
        add_sample(-5, 8'd1, 8'd1);
        add_sample(1001, 8'd1, 8'd1);
        add_sample(1000, 8'd0, 8'd0);
        add_sample(0, 8'd0, 8'd3);
        finish_run();
        settle();
        // inverted window drops everything
        cfg_write(CFG_RANGE_LOW, 10);
        cfg_write(CFG_RANGE_HIGH, 5);
        add_sample(7, 8'd2, 8'd2);
        finish_run();
        settle();
        // zero width acts as one: far too many bins, capped
        cfg_write(CFG_BIN_WIDTH, 0);
        finish_run();
        settle();
        cfg_write(CFG_BIN_WIDTH, 65535);
        cfg_write(CFG_RANGE_LOW, -32768);
        cfg_write(CFG_RANGE_HIGH, 32767);
        add_sample(-32768, 8'hFF, 8'hFF);
        add_sample(32767, 8'h00, 8'hFF);
        finish_run();
        settle();
        cfg_write(CFG_BIN_WIDTH, 1);
        finish_run();

        for (int phase = 0; phase < 6; phase++) begin
            settle();
            case ($urandom_range(2, 0))
                0:       cfg_write(CFG_BIN_WIDTH, $urandom_range(65535, 1));
                1:       cfg_write(CFG_BIN_WIDTH, $urandom_range(4000, 1));
                default: cfg_write(CFG_BIN_WIDTH, $urandom_range(30000, 500));
            endcase
            win_lo = int'($signed(VALUE_W'($urandom)));
            win_hi = int'($signed(VALUE_W'($urandom)));
            if (win_lo > win_hi && $urandom_range(5, 0) != 0) begin
                win_lo = win_lo + win_hi;
                win_hi = win_lo - win_hi;
                win_lo = win_lo - win_hi;
            end
            if (phase == 5) begin
                win_lo = -32768;
                win_hi = 32767;
            end
            cfg_write(CFG_RANGE_LOW, win_lo);
            cfg_write(CFG_RANGE_HIGH, win_hi);
            gap_odds = (phase == 2) ? 0 : 2 + phase;
            for (int n = 0; n < 40; n++) begin
                maybe_gap();
                if ($urandom_range(9, 0) == 0)
                    finish_run();
                else
                    random_add();
            end
            finish_run();
        end

        // last stretch, no idling from here on
        settle();
        gap_odds = 0;
        win_lo   = -32768;
        win_hi   = 32767;
        cfg_write(CFG_BIN_WIDTH, $urandom_range(2048, 1));
        cfg_write(CFG_RANGE_LOW, win_lo);
        cfg_write(CFG_RANGE_HIGH, win_hi);
        for (int n = 0; n < 10; n++)
            random_add();
        finish_run();
        random_add();
        finish_run();

        settle();
        repeat (50) @(posedge i_clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
`default_nettype wire
